@@ hdl/pnct_pkg.sv @@
// Package for the PN counter table: field widths, function codes and the
// operation codes of the shared arithmetic unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pnct_pkg;

  localparam int PEERS_DEF = 256;
  localparam int FUNC_W    = 2;
  localparam int PEER_W    = 8;
  localparam int COUNT_W   = 63;
  localparam int CLOCK_W   = 64;

  localparam logic [FUNC_W-1:0] FUNC_INC   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEC   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MERGE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd3;

  typedef enum logic [2:0] {
    ALU_ADD       = 3'd0,
    ALU_SUB       = 3'd1,
    ALU_MAX       = 3'd2,
    ALU_INC_SAT63 = 3'd3,
    ALU_INC_SAT64 = 3'd4
  } alu_op_t;

endpackage

`default_nettype wire

@@ hdl/pnct_alu.sv @@
// Shared 64-bit arithmetic unit of the PN counter table: one adder that serves
// add, subtract, maximum and saturating increment. Depends on pnct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pnct_alu (
  input  wire pnct_pkg::alu_op_t               op,
  input  wire logic [pnct_pkg::CLOCK_W-1:0]    a,
  input  wire logic [pnct_pkg::CLOCK_W-1:0]    b,
  output logic      [pnct_pkg::CLOCK_W-1:0]    y
);

  localparam int W = pnct_pkg::CLOCK_W;

  logic [W-1:0] b_eff;
  logic         cin;
  logic [W:0]   sum;

  // Subtract and compare use a + ~b + 1; increments use a + 0 + 1.
  always_comb begin
    unique case (op)
      pnct_pkg::ALU_ADD: begin
        b_eff = b;
        cin   = 1'b0;
      end
      pnct_pkg::ALU_SUB, pnct_pkg::ALU_MAX: begin
        b_eff = ~b;
        cin   = 1'b1;
      end
      default: begin
        b_eff = '0;
        cin   = 1'b1;
      end
    endcase
  end

  assign sum = {1'b0, a} + {1'b0, b_eff} + {{W{1'b0}}, cin};

  always_comb begin
    unique case (op)
      pnct_pkg::ALU_ADD, pnct_pkg::ALU_SUB: y = sum[W-1:0];
      // A carry out means a >= b.
      pnct_pkg::ALU_MAX:       y = sum[W] ? a : b;
      // A 63-bit count overflows into bit 62+1.
      pnct_pkg::ALU_INC_SAT63: y = sum[W-1] ? a : sum[W-1:0];
      pnct_pkg::ALU_INC_SAT64: y = sum[W] ? a : sum[W-1:0];
      default:                 y = sum[W-1:0];
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/pnct_table.sv @@
// Per-peer count memory of the PN counter table, with one valid bit per entry
// so that an entry never written reads as zero. Depends on pnct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pnct_table #(
  parameter int PEERS = pnct_pkg::PEERS_DEF,
  parameter int AW    = $clog2(PEERS),
  parameter int DW    = 2 * pnct_pkg::COUNT_W
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data
);

  logic [DW-1:0]    mem [PEERS];
  logic [PEERS-1:0] valid_r;
  logic [DW-1:0]    rd_data_r;
  logic             rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

`default_nettype wire

@@ hdl/pn_counter_table.sv @@
// Top level of the PN counter table: sequencer, Lamport clock, result register.
// Depends on pnct_pkg, pnct_alu and pnct_table.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Ports                                             Beat
// in        input      in_valid, in_stall, in_func, in_peer,              one item
//                      in_remote_plus, in_remote_minus, in_remote_clock
// out       output     out_valid, out_stall, out_status, out_total,      one result
//                      out_clock_now
//
// Each item is handled alone by a sequencer that drives one shared 64-bit
// arithmetic unit. An increment, decrement or merge steps through the table
// read, one step each for the positive count, the negative count and the
// clock, and the result load. A peer index out of range goes straight to the
// result load. A read walks the table with one add and one subtract per peer.
// Reset clears the clock and the valid bits of the table, so all counts read
// as zero afterwards. A stalled result waits in the output register; the
// sequencer holds its finished item until that register is free.

module pn_counter_table #(
  parameter int PEERS = pnct_pkg::PEERS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [pnct_pkg::FUNC_W-1:0]       in_func,
  input  wire logic [pnct_pkg::PEER_W-1:0]       in_peer,
  input  wire logic [pnct_pkg::COUNT_W-1:0]      in_remote_plus,
  input  wire logic [pnct_pkg::COUNT_W-1:0]      in_remote_minus,
  input  wire logic [pnct_pkg::CLOCK_W-1:0]      in_remote_clock,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_status,
  output logic signed [pnct_pkg::CLOCK_W-1:0]    out_total,
  output logic      [pnct_pkg::CLOCK_W-1:0]      out_clock_now
);

  localparam int AW  = $clog2(PEERS);
  localparam int CW  = pnct_pkg::COUNT_W;
  localparam int KW  = pnct_pkg::CLOCK_W;
  localparam int PW  = pnct_pkg::PEER_W;
  localparam int FW  = pnct_pkg::FUNC_W;
  localparam int DW  = 2 * CW;
  localparam logic [PW:0]   PEERS_L = (PW + 1)'(PEERS);
  localparam logic [AW-1:0] LAST_IX = AW'(PEERS - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PLUS  = 7'b0000010,
    S_MINUS = 7'b0000100,
    S_CLOCK = 7'b0001000,
    S_SUM_P = 7'b0010000,
    S_SUM_M = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [FW-1:0] func_r, func_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] rplus_r, rplus_nxt;
  logic [CW-1:0] rminus_r, rminus_nxt;
  logic [KW-1:0] rclock_r, rclock_nxt;
  logic [CW-1:0] plus_r, plus_nxt;
  logic [CW-1:0] minus_r, minus_nxt;
  logic [KW-1:0] acc_r, acc_nxt;
  logic          status_r, status_nxt;
  logic [KW-1:0] clock_r, clock_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_status_r, out_status_nxt;
  logic signed [KW-1:0] out_total_r, out_total_nxt;
  logic [KW-1:0]        out_clock_now_r, out_clock_now_nxt;

  logic              in_take;
  logic              in_range;
  logic              out_free;
  logic [AW-1:0]     rd_addr;
  logic [DW-1:0]     rd_data;
  logic [CW-1:0]     rd_plus;
  logic [CW-1:0]     rd_minus;
  logic              wr_en;
  pnct_pkg::alu_op_t alu_op;
  logic [KW-1:0]     alu_a;
  logic [KW-1:0]     alu_b;
  logic [KW-1:0]     alu_y;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && (state_r == S_IDLE);
  assign in_range = ({1'b0, in_peer} < PEERS_L);
  assign out_free = !out_valid_r || !out_stall;

  assign rd_plus  = rd_data[DW-1:CW];
  assign rd_minus = rd_data[CW-1:0];

  // The table read is registered, so the address for each step is presented
  // in the cycle before that step. A read pass starts at entry zero.
  always_comb begin
    unique case (state_r)
      S_IDLE:  rd_addr = (in_func == pnct_pkg::FUNC_READ) ? '0 : in_peer[AW-1:0];
      S_SUM_M: rd_addr = idx_r + AW'(1);
      default: rd_addr = idx_r;
    endcase
  end

  assign wr_en = (state_r == S_CLOCK);

  pnct_table #(
    .PEERS (PEERS),
    .AW    (AW),
    .DW    (DW)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (idx_r),
    .wr_data ({plus_r, minus_r})
  );

  // Operand selection for the shared unit. A count that the item leaves alone
  // passes through as the maximum of itself and zero.
  always_comb begin
    alu_op = pnct_pkg::ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state_r)
      S_PLUS: begin
        alu_a = {1'b0, rd_plus};
        priority if (func_r == pnct_pkg::FUNC_INC) begin
          alu_op = pnct_pkg::ALU_INC_SAT63;
        end else if (func_r == pnct_pkg::FUNC_MERGE) begin
          alu_op = pnct_pkg::ALU_MAX;
          alu_b  = {1'b0, rplus_r};
        end else begin
          alu_op = pnct_pkg::ALU_MAX;
        end
      end
      S_MINUS: begin
        alu_a = {1'b0, minus_r};
        priority if (func_r == pnct_pkg::FUNC_DEC) begin
          alu_op = pnct_pkg::ALU_INC_SAT63;
        end else if (func_r == pnct_pkg::FUNC_MERGE) begin
          alu_op = pnct_pkg::ALU_MAX;
          alu_b  = {1'b0, rminus_r};
        end else begin
          alu_op = pnct_pkg::ALU_MAX;
        end
      end
      S_CLOCK: begin
        alu_a = clock_r;
        if (func_r == pnct_pkg::FUNC_MERGE) begin
          alu_op = pnct_pkg::ALU_MAX;
          alu_b  = rclock_r;
        end else begin
          alu_op = pnct_pkg::ALU_INC_SAT64;
        end
      end
      S_SUM_P: begin
        alu_a = acc_r;
        alu_b = {1'b0, rd_plus};
      end
      S_SUM_M: begin
        alu_op = pnct_pkg::ALU_SUB;
        alu_a  = acc_r;
        alu_b  = {1'b0, rd_minus};
      end
      default: begin
        alu_op = pnct_pkg::ALU_ADD;
      end
    endcase
  end

  pnct_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  // Sequencer.
  always_comb begin
    state_nxt         = state_r;
    func_nxt          = func_r;
    idx_nxt           = idx_r;
    rplus_nxt         = rplus_r;
    rminus_nxt        = rminus_r;
    rclock_nxt        = rclock_r;
    plus_nxt          = plus_r;
    minus_nxt         = minus_r;
    acc_nxt           = acc_r;
    status_nxt        = status_r;
    clock_nxt         = clock_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_status_nxt    = out_status_r;
    out_total_nxt     = out_total_r;
    out_clock_now_nxt = out_clock_now_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          func_nxt   = in_func;
          rplus_nxt  = in_remote_plus;
          rminus_nxt = in_remote_minus;
          rclock_nxt = in_remote_clock;
          acc_nxt    = '0;
          status_nxt = 1'b0;
          if (in_func == pnct_pkg::FUNC_READ) begin
            idx_nxt   = '0;
            state_nxt = S_SUM_P;
          end else if (!in_range) begin
            status_nxt = 1'b1;
            state_nxt  = S_DONE;
          end else begin
            idx_nxt   = in_peer[AW-1:0];
            state_nxt = S_PLUS;
          end
        end
      end
      S_PLUS: begin
        plus_nxt  = alu_y[CW-1:0];
        minus_nxt = rd_minus;
        state_nxt = S_MINUS;
      end
      S_MINUS: begin
        minus_nxt = alu_y[CW-1:0];
        state_nxt = S_CLOCK;
      end
      S_CLOCK: begin
        clock_nxt = alu_y;
        state_nxt = S_DONE;
      end
      S_SUM_P: begin
        acc_nxt   = alu_y;
        state_nxt = S_SUM_M;
      end
      S_SUM_M: begin
        acc_nxt = alu_y;
        idx_nxt = idx_r + AW'(1);
        if (idx_r == LAST_IX) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SUM_P;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_status_nxt    = status_r;
          out_total_nxt     = $signed(acc_r);
          out_clock_now_nxt = clock_r;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clock_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clock_r     <= clock_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r          <= func_nxt;
    idx_r           <= idx_nxt;
    rplus_r         <= rplus_nxt;
    rminus_r        <= rminus_nxt;
    rclock_r        <= rclock_nxt;
    plus_r          <= plus_nxt;
    minus_r         <= minus_nxt;
    acc_r           <= acc_nxt;
    status_r        <= status_nxt;
    out_status_r    <= out_status_nxt;
    out_total_r     <= out_total_nxt;
    out_clock_now_r <= out_clock_now_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_total     = out_total_r;
  assign out_clock_now = out_clock_now_r;

endmodule

`default_nettype wire

@@ dv/tb_pn_counter_table.sv @@
// Self-checking testbench for pn_counter_table: random and directed beats with a
// mirror of the counter table that predicts every result. Depends on pnct_pkg and pn_counter_table.
`timescale 1ns / 1ps

module tb_pn_counter_table;

  localparam int FUNC_W  = pnct_pkg::FUNC_W;
  localparam int PEER_W  = pnct_pkg::PEER_W;
  localparam int COUNT_W = pnct_pkg::COUNT_W;
  localparam int CLOCK_W = pnct_pkg::CLOCK_W;

  localparam int NUM_PEERS = pnct_pkg::PEERS_DEF;
  localparam int RANDOM_ITEMS = 1230;
  localparam int LIMIT_CYCLES = 4_000_000;
  // A read, which walks every peer, is the longest item that the block handles.
  localparam int DRAIN_CYCLES = 2 * NUM_PEERS + 16;
  localparam int HOLD_CYCLES = 2500;

  localparam logic [COUNT_W-1:0] COUNT_TOP = '1;
  localparam logic [CLOCK_W-1:0] CLOCK_TOP = '1;

  typedef struct packed {
    logic               status;
    logic [CLOCK_W-1:0] total;
    logic [CLOCK_W-1:0] clock_now;
  } pn_result_t;

  // Mirror of the counter table. Every accepted input beat updates the mirrored
  // state and queues the result that the block must return for it.
  class pn_mirror;
    int                 peer_limit;
    logic [COUNT_W-1:0] plus_cnt[2**PEER_W];
    logic [COUNT_W-1:0] minus_cnt[2**PEER_W];
    logic [CLOCK_W-1:0] lamport;
    pn_result_t         expected_results[$];
    int                 errors;

    function new(int npeers);
      peer_limit = npeers;
      foreach (plus_cnt[i]) begin
        plus_cnt[i] = '0;
        minus_cnt[i] = '0;
      end
      lamport = '0;
      errors = 0;
    endfunction

    function void note_item(logic [FUNC_W-1:0] func, logic [PEER_W-1:0] peer,
                            logic [COUNT_W-1:0] rplus, logic [COUNT_W-1:0] rminus,
                            logic [CLOCK_W-1:0] rclock);
      pn_result_t r;
      logic [CLOCK_W-1:0] sum;
      int i;
      r = '0;
      sum = '0;
      if (func == pnct_pkg::FUNC_READ) begin
        // The sum wraps modulo 2^64, which plain 64-bit arithmetic gives.
        for (i = 0; i < peer_limit; i++) begin
          sum = sum + {1'b0, plus_cnt[i]} - {1'b0, minus_cnt[i]};
        end
        r.total = sum;
      end else if (int'(peer) >= peer_limit) begin
        r.status = 1'b1;
      end else if (func == pnct_pkg::FUNC_INC) begin
        if (plus_cnt[peer] != COUNT_TOP) plus_cnt[peer] = plus_cnt[peer] + 1'b1;
        if (lamport != CLOCK_TOP) lamport = lamport + 1'b1;
      end else if (func == pnct_pkg::FUNC_DEC) begin
        if (minus_cnt[peer] != COUNT_TOP) minus_cnt[peer] = minus_cnt[peer] + 1'b1;
        if (lamport != CLOCK_TOP) lamport = lamport + 1'b1;
      end else begin
        if (rplus > plus_cnt[peer]) plus_cnt[peer] = rplus;
        if (rminus > minus_cnt[peer]) minus_cnt[peer] = rminus;
        if (rclock > lamport) lamport = rclock;
      end
      r.clock_now = lamport;
      expected_results.push_back(r);
    endfunction

    function void check_result(logic status, logic [CLOCK_W-1:0] total,
                               logic [CLOCK_W-1:0] clock_now);
      pn_result_t e;
      if (expected_results.size() == 0) begin
        $error("result beat with no expectation: status %0d total %0d clock_now %0d",
               status, $signed(total), clock_now);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, status);
        errors++;
      end
      if (total !== e.total) begin
        $error("total: expected %0d, actual %0d", $signed(e.total), $signed(total));
        errors++;
      end
      if (clock_now !== e.clock_now) begin
        $error("clock_now: expected %0d, actual %0d", e.clock_now, clock_now);
        errors++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  // Clock, reset and every block input start at known values.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [FUNC_W-1:0] in_func = pnct_pkg::FUNC_INC;
  logic [PEER_W-1:0] in_peer = '0;
  logic [COUNT_W-1:0] in_remote_plus = '0;
  logic [COUNT_W-1:0] in_remote_minus = '0;
  logic [CLOCK_W-1:0] in_remote_clock = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic out_status;
  logic signed [CLOCK_W-1:0] out_total;
  logic [CLOCK_W-1:0] out_clock_now;

  // Idle rates in percent, changed by the stimulus as it moves through its phases.
  int unsigned tx_idle_pct = 8;
  int unsigned rx_idle_pct = 61;
  bit pressure_go = 1'b0;
  bit pressure_done = 1'b0;
  int unsigned cycle_cnt = 0;

  pn_mirror table_mirror;

  always #2 clk = ~clk;

  pn_counter_table #(
    .PEERS(NUM_PEERS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(in_func),
    .in_peer(in_peer),
    .in_remote_plus(in_remote_plus),
    .in_remote_minus(in_remote_minus),
    .in_remote_clock(in_remote_clock),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_total(out_total),
    .out_clock_now(out_clock_now)
  );

  // Offers one beat, with random idle cycles ahead of it, and holds the payload
  // steady until the block takes it. Signals are sampled right after the edge,
  // so in_stall is the value the block showed at that edge.
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [PEER_W-1:0] p,
                           input logic [COUNT_W-1:0] rp, input logic [COUNT_W-1:0] rm,
                           input logic [CLOCK_W-1:0] rc);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_peer <= p;
    in_remote_plus <= rp;
    in_remote_minus <= rm;
    in_remote_clock <= rc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    table_mirror.note_item(f, p, rp, rm, rc);
  endtask

  // Remote counts land near the local count half of the time, so that a merge
  // sometimes wins and sometimes loses; the rest are small or span all 63 bits.
  function automatic logic [COUNT_W-1:0] pick_count(input logic [COUNT_W-1:0] cur);
    int unsigned sel;
    logic [63:0] wide;
    logic [COUNT_W-1:0] base;
    logic [COUNT_W-1:0] delta;
    sel = $urandom_range(99);
    wide = {$urandom, $urandom};
    delta = COUNT_W'($urandom_range(40));
    base = (cur < COUNT_W'(20)) ? '0 : cur - COUNT_W'(20);
    if (sel < 25) return wide[COUNT_W-1:0];
    if (sel < 50) return COUNT_W'($urandom_range(1000));
    return (COUNT_TOP - base < delta) ? COUNT_TOP : base + delta;
  endfunction

  // Same idea for the remote clock. Wide values are rare so that the clock
  // does not run into its ceiling before the last beats aim at it on purpose.
  function automatic logic [CLOCK_W-1:0] pick_clock(input logic [CLOCK_W-1:0] cur);
    int unsigned sel;
    logic [CLOCK_W-1:0] base;
    sel = $urandom_range(99);
    base = (cur < CLOCK_W'(20)) ? '0 : cur - CLOCK_W'(20);
    if (sel < 10) return {$urandom, $urandom};
    if (sel < 35) return CLOCK_W'($urandom_range(500));
    return base + CLOCK_W'($urandom_range(40));
  endfunction

  task automatic send_random_item();
    int unsigned sel;
    logic [FUNC_W-1:0] f;
    logic [PEER_W-1:0] p;
    logic [63:0] noise_a;
    logic [63:0] noise_b;
    logic [CLOCK_W-1:0] rc;
    sel = $urandom_range(99);
    noise_a = {$urandom, $urandom};
    noise_b = {$urandom, $urandom};
    rc = {$urandom, $urandom};
    // A narrow peer range now and then piles several updates on the same entry.
    p = ($urandom_range(99) < 30) ? PEER_W'($urandom_range(7)) : PEER_W'($urandom_range(255));
    if (sel < 35) f = pnct_pkg::FUNC_INC;
    else if (sel < 65) f = pnct_pkg::FUNC_DEC;
    else if (sel < 90) f = pnct_pkg::FUNC_MERGE;
    else f = pnct_pkg::FUNC_READ;
    if (f == pnct_pkg::FUNC_MERGE) begin
      send_item(f, p, pick_count(table_mirror.plus_cnt[p]),
                pick_count(table_mirror.minus_cnt[p]), pick_clock(table_mirror.lamport));
    end else begin
      // The remote fields carry noise that the block has to ignore.
      send_item(f, p, noise_a[COUNT_W-1:0], noise_b[COUNT_W-1:0], rc);
    end
  endtask

  // Receiving side. Results are checked at the edge that accepts them, and the
  // stall for the next cycle is drawn right after. Once, at the start of the
  // last phase, the receiver holds off for a long stretch so that the output
  // register and the sequencer fill up and the block stalls its input.
  initial begin : result_side
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        table_mirror.check_result(out_status, out_total, out_clock_now);
      end
      if (pressure_go && !pressure_done) begin
        pressure_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Watchdog: a run that hangs ends here.
  initial begin : watchdog
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAIL pn_counter_table");
    $finish;
  end

  initial begin : stimulus
    int k;
    table_mirror = new(NUM_PEERS);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats. A read straight out of reset must see an empty table.
    send_item(pnct_pkg::FUNC_READ, '0, '0, '0, '0);
    send_item(pnct_pkg::FUNC_INC, 8'd0, '0, '0, '0);
    send_item(pnct_pkg::FUNC_DEC, 8'd0, '0, '0, '0);
    send_item(pnct_pkg::FUNC_INC, 8'd255, '0, '0, '0);
    send_item(pnct_pkg::FUNC_DEC, 8'd255, '0, '0, '0);
    send_item(pnct_pkg::FUNC_DEC, 8'd255, '0, '0, '0);
    // A merge that raises everything, then one whose values all lose.
    send_item(pnct_pkg::FUNC_MERGE, 8'd128, COUNT_W'(1000), COUNT_W'(10), CLOCK_W'(50));
    send_item(pnct_pkg::FUNC_MERGE, 8'd128, COUNT_W'(5), COUNT_W'(3), CLOCK_W'(7));
    // Push counts to their ceiling and check that an update leaves them there.
    send_item(pnct_pkg::FUNC_MERGE, 8'd0, COUNT_TOP, '0, CLOCK_W'(60));
    send_item(pnct_pkg::FUNC_INC, 8'd0, '0, '0, '0);
    send_item(pnct_pkg::FUNC_MERGE, 8'd1, '0, COUNT_TOP, '0);
    send_item(pnct_pkg::FUNC_DEC, 8'd1, '0, '0, '0);
    send_item(pnct_pkg::FUNC_MERGE, 8'd2, COUNT_TOP, '0, '0);
    // Two full positive counts overflow the 64-bit sum.
    send_item(pnct_pkg::FUNC_READ, '0, '0, '0, '0);
    // Remote fields on an update and peer and remote fields on a read are ignored.
    send_item(pnct_pkg::FUNC_INC, 8'd3, COUNT_TOP, COUNT_TOP, CLOCK_TOP);
    send_item(pnct_pkg::FUNC_READ, 8'd77, COUNT_TOP, COUNT_TOP, CLOCK_TOP);
    send_item(pnct_pkg::FUNC_MERGE, 8'd1, COUNT_TOP, COUNT_TOP, CLOCK_W'(64));
    send_item(pnct_pkg::FUNC_READ, 8'd255, '0, '0, '0);

    // Random beats in three phases: receiver slow, sender slow, then both fast
    // with one long receiver hold-off at the start.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS / 3) begin
        tx_idle_pct = 61;
        rx_idle_pct = 8;
      end else if (k == 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        pressure_go = 1'b1;
      end
      send_random_item();
    end

    // The clock ceiling comes last, since the clock never leaves it.
    send_item(pnct_pkg::FUNC_MERGE, 8'd4, '0, '0, CLOCK_TOP - 1'b1);
    send_item(pnct_pkg::FUNC_INC, 8'd4, '0, '0, '0);
    send_item(pnct_pkg::FUNC_DEC, 8'd5, '0, '0, '0);
    send_item(pnct_pkg::FUNC_MERGE, 8'd6, COUNT_W'(3), COUNT_W'(3), '0);
    send_item(pnct_pkg::FUNC_READ, '0, '0, '0, '0);
    in_valid <= 1'b0;

    while (table_mirror.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (table_mirror.errors == 0 && table_mirror.pending() == 0) begin
      $display("PASS pn_counter_table");
    end else begin
      $display("FAIL pn_counter_table");
    end
    $finish;
  end

endmodule
